### src/dqu_pkg.sv
// Shared types and codes for the double-ended queue unit.
// No dependencies; imported by the cell and the top level.
package dqu_pkg;

  localparam int DATA_W  = 32;
  localparam int FUNC_W  = 3;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  // Operation codes carried on func
  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] OP_NONE       = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Qualified command broadcast to every cell (at most one bit set)
  typedef struct packed {
    logic head_push;
    logic tail_push;
    logic head_pop;
    logic tail_pop;
  } cell_cmd_t;

endpackage

### src/dqu_cell.sv
// One storage cell of the queue chain: a data word and an occupied bit.
// Depends on dqu_pkg for the command struct and data width.
module dqu_cell
  import dqu_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] push_value,
  input  logic [DATA_W-1:0] prev_data,
  input  logic              prev_valid,
  input  logic [DATA_W-1:0] next_data,
  input  logic              next_valid,
  output logic [DATA_W-1:0] data,
  output logic              valid,
  output logic [DATA_W-1:0] back_term
);

  logic              is_last;
  logic              first_free;
  logic [DATA_W-1:0] data_next;
  logic              valid_next;

  assign is_last    = valid & ~next_valid;
  assign first_free = ~valid & prev_valid;
  assign back_term  = data & {DATA_W{is_last}};

  // Select shift toward the back, shift toward the front, fill or drop
  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (cmd.head_push) begin
      data_next  = prev_data;
      valid_next = prev_valid;
    end else if (cmd.tail_push) begin
      if (first_free) begin
        data_next  = push_value;
        valid_next = 1'b1;
      end
    end else if (cmd.head_pop) begin
      data_next  = next_data;
      valid_next = next_valid;
    end else if (cmd.tail_pop) begin
      if (is_last) begin
        valid_next = 1'b0;
      end
    end
  end

  // Hold data without reset; clear the occupied bit on reset
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

### src/double_ended_queue_unit.sv
// Top level of the double-ended queue unit: command decode, count, status
// and the chain of dqu_cell storage cells. Depends on dqu_pkg and dqu_cell.
//
// A bounded deque of DEPTH 32-bit words held in a row of cells, the front in
// the first cell. A command is taken whenever start is high and busy is low;
// busy is high only during reset and in the first cycle after it, so one
// operation is taken every clock. The cells shift or fill at the edge that
// takes the command, and in the next cycle done pulses for one cycle with
// front_value, back_value, count and status for that operation. Results
// are not held, so they must be captured while done is high. A push into a
// full queue is dropped with status full; a pop from an empty queue is
// ignored with status empty; whenever the queue is empty afterwards, both
// values read as zero and status is empty.
module double_ended_queue_unit
  import dqu_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FUNC_W-1:0]  func,
  input  logic [DATA_W-1:0]  push_value,
  output logic               done,
  output logic [DATA_W-1:0]  front_value,
  output logic [DATA_W-1:0]  back_value,
  output logic [COUNT_W-1:0] count,
  output logic [STAT_W-1:0]  status
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic                      accept;
  logic                      full;
  logic                      empty;
  cell_cmd_t                 cmd;
  logic [CW-1:0]             cnt;
  logic [CW-1:0]             cnt_next;
  logic [STAT_W-1:0]         op_status;
  logic [STAT_W-1:0]         op_status_next;
  logic [CW+COUNT_W-1:0]     cnt_ext;
  logic [DEPTH-1:0][DATA_W-1:0] cell_data;
  logic [DEPTH-1:0]          cell_valid;
  logic [DEPTH-1:0][DATA_W-1:0] cell_back;
  logic [DATA_W-1:0]         back_any;

  assign accept = start & ~busy;
  assign full   = (cnt == FULL_COUNT);
  assign empty  = (cnt == '0);

  // Decode the command and qualify it against full and empty
  always_comb begin
    cmd            = '0;
    cnt_next       = cnt;
    op_status_next = ST_OK;
    if (accept) begin
      unique case (func) inside
        OP_PUSH_FRONT, OP_PUSH_BACK: begin
          if (full) begin
            op_status_next = ST_FULL;
          end else begin
            cmd.head_push = (func == OP_PUSH_FRONT);
            cmd.tail_push = (func == OP_PUSH_BACK);
            cnt_next      = cnt + CW'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          if (empty) begin
            op_status_next = ST_EMPTY;
          end else begin
            cmd.head_pop = (func == OP_POP_FRONT);
            cmd.tail_pop = (func == OP_POP_BACK);
            cnt_next     = cnt - CW'(1);
          end
        end
        default: begin
          op_status_next = ST_OK;
        end
      endcase
    end
  end

  // Advance count, status and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      op_status <= ST_OK;
      done      <= 1'b0;
      busy      <= 1'b1;
    end else begin
      busy <= 1'b0;
      done <= accept;
      if (accept) begin
        cnt       <= cnt_next;
        op_status <= op_status_next;
      end
    end
  end

  // Chain of cells: each takes its neighbors' words for a shift
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_d;
    logic              prev_v;
    logic [DATA_W-1:0] next_d;
    logic              next_v;

    if (i == 0) begin : g_first
      assign prev_d = push_value;
      assign prev_v = 1'b1;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
      assign prev_v = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_d = '0;
      assign next_v = 1'b0;
    end else begin : g_inner
      assign next_d = cell_data[i+1];
      assign next_v = cell_valid[i+1];
    end

    dqu_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .push_value (push_value),
      .prev_data  (prev_d),
      .prev_valid (prev_v),
      .next_data  (next_d),
      .next_valid (next_v),
      .data       (cell_data[i]),
      .valid      (cell_valid[i]),
      .back_term  (cell_back[i])
    );
  end

  // Merge the back words; only the last occupied cell contributes
  always_comb begin
    back_any = '0;
    for (int i = 0; i < DEPTH; i++) begin
      back_any = back_any | cell_back[i];
    end
  end

  assign front_value = empty ? '0 : cell_data[0];
  assign back_value  = empty ? '0 : back_any;
  assign cnt_ext     = {{COUNT_W{1'b0}}, cnt};
  assign count       = cnt_ext[COUNT_W-1:0];
  assign status      = (empty && op_status == ST_OK) ? ST_EMPTY : op_status;

  // The first cell is occupied exactly when the count is nonzero
  a_front_tracks_count: assert property (@(posedge clk) disable iff (rst)
    cell_valid[0] == (cnt != '0))
    else $error("front cell occupancy disagrees with count");

  // A result follows every taken command in the next cycle
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("missing result after a taken command");

  // A dropped push leaves the queue full
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_FULL) |-> (cnt == FULL_COUNT))
    else $error("full status reported while not full");

  // An empty status always comes with zero count and zero values
  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_EMPTY) |-> (cnt == '0 && front_value == '0
                                      && back_value == '0))
    else $error("empty status with stored elements");

endmodule

### tb/sv/tb_double_ended_queue_unit.sv
// Self-checking testbench for double_ended_queue_unit: drives push, pop and
// no-change commands, predicts each result with a local ring model and checks
// every done transfer. Depends on dqu_pkg and the RTL of the unit.
module tb_double_ended_queue_unit;
  import dqu_pkg::*;

  localparam int RING_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int EXP_DEPTH   = 16;

  // One expected result of the unit
  typedef struct {
    logic [DATA_W-1:0]  front;
    logic [DATA_W-1:0]  back;
    logic [COUNT_W-1:0] fill;
    logic [STAT_W-1:0]  stat;
  } deque_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [FUNC_W-1:0]  func = OP_NONE;
  logic [DATA_W-1:0]  push_value = '0;
  logic               done;
  logic [DATA_W-1:0]  front_value;
  logic [DATA_W-1:0]  back_value;
  logic [COUNT_W-1:0] count;
  logic [STAT_W-1:0]  status;

  // Local copy of the deque state
  logic [DATA_W-1:0]  ring_mem [RING_DEPTH];
  logic [3:0]         ring_head;
  logic [COUNT_W-1:0] ring_fill;

  // Expected results waiting for their transfer
  deque_result_t      exp_fifo [EXP_DEPTH];
  int                 exp_wr = 0;
  int                 exp_rd = 0;
  bit                 idle_en = 1'b0;
  int                 err_cnt = 0;
  int                 cycle_cnt = 0;

  double_ended_queue_unit #(.DEPTH(RING_DEPTH)) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .func        (func),
    .push_value  (push_value),
    .done        (done),
    .front_value (front_value),
    .back_value  (back_value),
    .count       (count),
    .status      (status)
  );

  always #4 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Apply one operation to the local deque and return the result it gives
  function automatic deque_result_t apply_deque_op(logic [FUNC_W-1:0] op,
                                                   logic [DATA_W-1:0] val);
    deque_result_t res;
    logic [STAT_W-1:0] st;
    logic [3:0] tail;
    st = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (ring_fill >= RING_DEPTH) begin
          st = ST_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            ring_head = ring_head - 4'd1;
            ring_mem[ring_head] = val;
          end else begin
            ring_mem[ring_head + ring_fill[3:0]] = val;
          end
          ring_fill = ring_fill + 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (ring_fill == 0) begin
          st = ST_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) ring_head = ring_head + 4'd1;
          ring_fill = ring_fill - 1'b1;
        end
      end
      default: ;
    endcase
    if (ring_fill == 0) begin
      res.front = '0;
      res.back  = '0;
      if (st == ST_OK) st = ST_EMPTY;
    end else begin
      tail = ring_head + ring_fill[3:0] - 4'd1;
      res.front = ring_mem[ring_head];
      res.back  = ring_mem[tail];
    end
    res.fill = ring_fill;
    res.stat = st;
    return res;
  endfunction

  // Drive one command and hold it until the unit takes it
  task automatic send_op(input logic [FUNC_W-1:0] op, input logic [DATA_W-1:0] val);
    if (idle_en) begin
      while ($urandom_range(99) < 29) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start      <= 1'b1;
    func       <= op;
    push_value <= val;
    do @(posedge clk); while (busy);
    exp_fifo[exp_wr % EXP_DEPTH] = apply_deque_op(op, val);
    exp_wr++;
  endtask

  // Compare each done transfer with the oldest expectation
  always @(posedge clk) begin
    deque_result_t exp_res;
    if (!rst && done) begin
      if (exp_rd == exp_wr) begin
        $display("%0t: unexpected result front=%h back=%h count=%0d status=%0d",
                 $time, front_value, back_value, count, status);
        err_cnt++;
      end else begin
        exp_res = exp_fifo[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (front_value !== exp_res.front) begin
          $display("%0t: front_value expected %h actual %h", $time, exp_res.front,
                   front_value);
          err_cnt++;
        end
        if (back_value !== exp_res.back) begin
          $display("%0t: back_value expected %h actual %h", $time, exp_res.back,
                   back_value);
          err_cnt++;
        end
        if (count !== exp_res.fill) begin
          $display("%0t: count expected %0d actual %0d", $time, exp_res.fill, count);
          err_cnt++;
        end
        if (status !== exp_res.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.stat, status);
          err_cnt++;
        end
      end
    end
  end

  // Operations on an empty deque, including the unused selectors
  task automatic test_empty_ops();
    send_op(OP_NONE, 32'h1234_5678);
    send_op(OP_POP_FRONT, 32'hFFFF_FFFF);
    send_op(OP_POP_BACK, 32'h0);
    send_op(3'd5, 32'hDEAD_BEEF);
    send_op(3'd6, 32'h0);
    send_op(3'd7, 32'hFFFF_FFFF);
  endtask

  // Fill to capacity from both ends, overflow, then shrink from both ends
  task automatic test_fill_and_overflow();
    int i;
    send_op(OP_PUSH_BACK, 32'h0);
    send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
    for (i = 2; i < RING_DEPTH; i++) begin
      send_op((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
    end
    send_op(OP_PUSH_FRONT, 32'hAAAA_AAAA);
    send_op(OP_PUSH_BACK, 32'h5555_5555);
    send_op(OP_POP_FRONT, 32'h0);
    send_op(OP_POP_BACK, 32'h0);
  endtask

  // Random traffic in phases that lean toward filling, draining or balance
  task automatic test_random_traffic(input int n_items);
    int i;
    int mode;
    int r;
    int push_pct;
    logic [FUNC_W-1:0] op;
    logic [DATA_W-1:0] val;
    mode = 0;
    for (i = 0; i < n_items; i++) begin
      // no idling over the first stretch, then idle at random
      idle_en = (i >= 120);
      if (i % 30 == 0) mode = $urandom_range(2);
      push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
      r = $urandom_range(99);
      if (r < 6) begin
        op = 3'($urandom_range(4, 7));
      end else if ($urandom_range(99) < push_pct) begin
        op = $urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
        op = $urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT;
      end
      r = $urandom_range(99);
      if (r < 8)       val = '0;
      else if (r < 16) val = '1;
      else             val = $urandom;
      send_op(op, val);
    end
  endtask

  initial begin
    ring_head = '0;
    ring_fill = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_empty_ops();
    test_fill_and_overflow();
    test_random_traffic(550);
    start <= 1'b0;
    // drain outstanding results, then allow for the pipeline
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
